// ===== src/dersig_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER signature parser package
// Shared types and fixed constants of the DER ECDSA signature parser.
// ----------------------------------------------------------------------------
package dersig_pkg;

  // DER tags.
  localparam logic [7:0] SEQ_TAG = 8'h30;
  localparam logic [7:0] INT_TAG = 8'h02;

  // Byte counter saturates at its all-ones value.
  localparam int unsigned CNT_W         = 7;
  localparam logic [CNT_W-1:0] CNT_MAX  = 7'd127;
  localparam logic [CNT_W-1:0] MIN_SIG_BYTES = 7'd8;

  // Each integer is presented through a 32-byte window, four 64-bit words.
  localparam int unsigned WIN_BYTES  = 32;
  localparam int unsigned WIN_BITS   = WIN_BYTES * 8;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned OUT_WORDS  = (2 * WIN_BITS) / WORD_BITS;
  localparam int unsigned IDX_W      = $clog2(OUT_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(OUT_WORDS - 1);

  // Parse phases, one-hot.
  typedef enum logic [8:0] {
    PH_SEQ_TAG = 9'b0_0000_0001,
    PH_SEQ_LEN = 9'b0_0000_0010,
    PH_R_TAG   = 9'b0_0000_0100,
    PH_R_LEN   = 9'b0_0000_1000,
    PH_R_DATA  = 9'b0_0001_0000,
    PH_S_TAG   = 9'b0_0010_0000,
    PH_S_LEN   = 9'b0_0100_0000,
    PH_S_DATA  = 9'b0_1000_0000,
    PH_DONE    = 9'b1_0000_0000
  } phase_e;

  // Handoff from the parser to the output buffer on a final byte.
  typedef struct packed {
    logic fire;  // final byte accepted this cycle
    logic ok;    // signature parsed correctly
  } done_t;

endpackage

// ===== src/dersig_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER signature byte parser
// Walks the DER structure one byte per cycle while accept_i is high and shifts r and s
// into right-aligned 32-byte windows.
// ----------------------------------------------------------------------------
module dersig_parser #(
  parameter int INT_BYTES     = 32,
  parameter int MAX_SIG_BYTES = 72
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    sig_byte_i,
  input  logic                          final_byte_i,
  output dersig_pkg::done_t             done_o,
  output logic [dersig_pkg::WIN_BITS-1:0] r_o,
  output logic [dersig_pkg::WIN_BITS-1:0] s_o
);
  import dersig_pkg::*;

  localparam int LEN_W = $clog2(INT_BYTES + 2);
  localparam logic [7:0]       MaxLenByte = 8'(INT_BYTES + 1);
  localparam logic [LEN_W-1:0] MaxLen     = LEN_W'(INT_BYTES + 1);
  localparam logic [CNT_W-1:0] MaxSig     = CNT_W'(MAX_SIG_BYTES);

  phase_e              phase_q, phase_d, phase_n;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_n;
  logic [7:0]          seq_q, seq_d, seq_n;
  logic [LEN_W-1:0]    flen_q, flen_d, flen_n;
  logic [LEN_W-1:0]    taken_q, taken_d, taken_n;
  logic                err_q, err_d, err_n;
  logic [WIN_BITS-1:0] r_q, r_d, r_n;
  logic [WIN_BITS-1:0] s_q, s_d, s_n;
  logic                sign_pos;
  logic                store;

  // Next state after taking one byte, before the end-of-signature clear.
  always_comb begin
    phase_n  = phase_q;
    seq_n    = seq_q;
    flen_n   = flen_q;
    taken_n  = taken_q;
    err_n    = err_q;
    r_n      = r_q;
    s_n      = s_q;
    sign_pos = (flen_q == MaxLen) && (taken_q == '0);
    store    = 1'b0;
    if (!err_q) begin
      case (phase_q)
        PH_SEQ_TAG: begin
          if (sig_byte_i != SEQ_TAG) err_n = 1'b1;
          else phase_n = PH_SEQ_LEN;
        end
        PH_SEQ_LEN: begin
          seq_n   = sig_byte_i;
          phase_n = PH_R_TAG;
        end
        PH_R_TAG, PH_S_TAG: begin
          if (sig_byte_i != INT_TAG) err_n = 1'b1;
          else phase_n = (phase_q == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
        end
        PH_R_LEN, PH_S_LEN: begin
          if (sig_byte_i == 8'd0 || sig_byte_i > MaxLenByte) begin
            err_n = 1'b1;
          end else begin
            flen_n  = LEN_W'(sig_byte_i);
            taken_n = '0;
            phase_n = (phase_q == PH_R_LEN) ? PH_R_DATA : PH_S_DATA;
          end
        end
        PH_R_DATA, PH_S_DATA: begin
          if (sign_pos) begin
            if (sig_byte_i != 8'd0) err_n = 1'b1;
          end else begin
            store = 1'b1;
          end
          taken_n = taken_q + 1'b1;
          if (taken_n >= flen_q) begin
            phase_n = (phase_q == PH_R_DATA) ? PH_S_TAG : PH_DONE;
          end
          // Shifting in keeps the integer right-aligned in its window.
          if (store && phase_q == PH_R_DATA) r_n = {r_q[WIN_BITS-9:0], sig_byte_i};
          if (store && phase_q == PH_S_DATA) s_n = {s_q[WIN_BITS-9:0], sig_byte_i};
        end
        default: begin
          err_n = 1'b1;
        end
      endcase
    end
    if (cnt_q >= CNT_MAX) begin
      err_n = 1'b1;
      cnt_n = cnt_q;
    end else begin
      cnt_n = cnt_q + 1'b1;
    end
  end

  always_comb begin
    done_o.fire = accept_i && final_byte_i;
    done_o.ok   = !err_n && (phase_n == PH_DONE) &&
                  (cnt_n >= MIN_SIG_BYTES) && (cnt_n <= MaxSig) &&
                  ({1'b0, seq_n} + 9'd2 == {2'b00, cnt_n});
    r_o = r_n;
    s_o = s_n;
  end

  // Every accepted final byte returns the parser to its reset state.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    seq_d   = seq_q;
    flen_d  = flen_q;
    taken_d = taken_q;
    err_d   = err_q;
    r_d     = r_q;
    s_d     = s_q;
    if (accept_i) begin
      if (final_byte_i) begin
        phase_d = PH_SEQ_TAG;
        cnt_d   = '0;
        seq_d   = '0;
        flen_d  = '0;
        taken_d = '0;
        err_d   = 1'b0;
        r_d     = '0;
        s_d     = '0;
      end else begin
        phase_d = phase_n;
        cnt_d   = cnt_n;
        seq_d   = seq_n;
        flen_d  = flen_n;
        taken_d = taken_n;
        err_d   = err_n;
        r_d     = r_n;
        s_d     = s_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEQ_TAG;
      cnt_q   <= '0;
      seq_q   <= '0;
      flen_q  <= '0;
      taken_q <= '0;
      err_q   <= 1'b0;
      r_q     <= '0;
      s_q     <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      seq_q   <= seq_d;
      flen_q  <= flen_d;
      taken_q <= taken_d;
      err_q   <= err_d;
      r_q     <= r_d;
      s_q     <= s_d;
    end
  end

endmodule

// ===== src/dersig_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER signature result buffer
// Holds r and s of one parsed signature and hands them out as 64-bit words.
// ----------------------------------------------------------------------------
module dersig_out_buf (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dersig_pkg::done_t               done_i,
  input  logic [dersig_pkg::WIN_BITS-1:0] r_i,
  input  logic [dersig_pkg::WIN_BITS-1:0] s_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [dersig_pkg::WORD_BITS-1:0] word_o,
  output logic [dersig_pkg::IDX_W-1:0]    word_index_o,
  output logic                            sig_ok_o,
  output logic                            run_end_o,
  output logic                            free_o
);
  import dersig_pkg::*;

  logic                  valid_q, valid_d;
  logic                  ok_q, ok_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [2*WIN_BITS-1:0] data_q, data_d;

  assign word_o       = data_q[2*WIN_BITS-1 -: WORD_BITS];
  assign word_index_o = idx_q;
  assign sig_ok_o     = ok_q;
  assign out_valid_o  = valid_q;
  // A rejected signature is a run of one result.
  assign run_end_o    = !ok_q || (idx_q == LAST_IDX);
  // The buffer can take a new run once the last word of the current one leaves.
  assign free_o       = !valid_q || (out_ready_i && run_end_o);

  always_comb begin
    valid_d = valid_q;
    ok_d    = ok_q;
    idx_d   = idx_q;
    data_d  = data_q;
    if (valid_q && out_ready_i) begin
      if (run_end_o) begin
        valid_d = 1'b0;
      end else begin
        idx_d  = idx_q + 1'b1;
        data_d = {data_q[2*WIN_BITS-WORD_BITS-1:0], {WORD_BITS{1'b0}}};
      end
    end
    if (done_i.fire) begin
      valid_d = 1'b1;
      ok_d    = done_i.ok;
      idx_d   = '0;
      data_d  = done_i.ok ? {r_i, s_i} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ok_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ok_q    <= ok_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== src/der_ecdsa_signature_parser_top.sv =====
`timescale 1ns / 1ps
// The first result of a signature is shown in the cycle after its final byte is taken.
// Throughput: one signature byte per cycle; an accepted signature yields eight words,
// one per cycle while out_ready_i is high, from a single result buffer, so a final byte
// waits while that buffer still holds words of the previous signature. Non-final bytes
// are never held back. Reset: rst_ni is asynchronous and active low; it returns the
// parser to the sequence tag and empties the result buffer.
// ----------------------------------------------------------------------------
// DER ECDSA signature parser, top level
// Parses SEQUENCE { INTEGER r, INTEGER s } byte by byte and delivers r and s
// as eight 64-bit big-endian words, or a single reject result.
// ----------------------------------------------------------------------------
module der_ecdsa_signature_parser_top #(
  parameter int INT_BYTES     = 32,
  parameter int MAX_SIG_BYTES = 72
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input channel: one signature byte per transaction.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       sig_byte_i,
  input  logic                             final_byte_i,
  // Output channel: one 64-bit word per transaction.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dersig_pkg::WORD_BITS-1:0] word_o,
  output logic [dersig_pkg::IDX_W-1:0]     word_index_o,
  output logic                             sig_ok_o,
  output logic                             run_end_o
);
  import dersig_pkg::*;

  logic                in_accept;
  logic                buf_free;
  done_t               done;
  logic [WIN_BITS-1:0] r_win;
  logic [WIN_BITS-1:0] s_win;

  // Bytes in the middle of a signature only touch the parser state, so they
  // are always taken. A final byte loads the result buffer in the same cycle,
  // so it is taken only when the buffer is empty or its last word is leaving.
  assign in_ready_o = !final_byte_i || buf_free;
  assign in_accept  = in_valid_i && in_ready_o;

  // The parser holds the phase, counters and the two shift windows. On a
  // final byte it reports the verdict together with the windows including
  // that byte, and clears itself for the next signature.
  dersig_parser #(
    .INT_BYTES    (INT_BYTES),
    .MAX_SIG_BYTES(MAX_SIG_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .sig_byte_i   (sig_byte_i),
    .final_byte_i (final_byte_i),
    .done_o       (done),
    .r_o          (r_win),
    .s_o          (s_win)
  );

  // The result buffer keeps a copy of both windows, so the next signature can
  // be parsed while the words of this one drain.
  dersig_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .done_i       (done),
    .r_i          (r_win),
    .s_i          (s_win),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .word_o       (word_o),
    .word_index_o (word_index_o),
    .sig_ok_o     (sig_ok_o),
    .run_end_o    (run_end_o),
    .free_o       (buf_free)
  );

`ifndef ASSERT_OFF
  // A reject result is a lone, all-zero word at index zero.
  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sig_ok_o) |-> (run_end_o && word_o == '0 && word_index_o == '0))
    else $error("reject result is not a single zero word");

  // Within an accepted run the word index steps by one per transaction.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !run_end_o) |=>
      (out_valid_o && word_index_o == IDX_W'($past(word_index_o) + 1'b1)))
    else $error("word index did not advance within a run");

  // After the last word of a run leaves, nothing is shown unless a new
  // signature finished in that same cycle.
  a_run_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && run_end_o && !(in_accept && final_byte_i)) |=>
      !out_valid_o)
    else $error("result shown after the run ended");

  // A final byte is never taken while an unfinished run still occupies the buffer.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && final_byte_i && out_valid_o) |-> (out_ready_i && run_end_o))
    else $error("final byte accepted over a pending run");
`endif

endmodule

// ===== sim/der_ecdsa_signature_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER ECDSA signature parser testbench
// Feeds DER-encoded signatures byte by byte, some well formed and some broken,
// predicts the r/s words or the reject result of each one, and compares every
// output transaction with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module der_ecdsa_signature_parser_top_tb;
  import dersig_pkg::*;

  localparam int INT_BYTES     = 32;
  localparam int MAX_SIG_BYTES = 72;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int RANDOM_BYTES  = 100;

  // Ways in which a generated signature can be broken.
  typedef enum int {
    FLAW_NONE,
    FLAW_SEQ_TAG,
    FLAW_SEQ_LEN,
    FLAW_R_TAG,
    FLAW_S_TAG,
    FLAW_LEN_ZERO,
    FLAW_LEN_HUGE,
    FLAW_SIGN,
    FLAW_SHORT,
    FLAW_TRAIL,
    FLAW_NOISE
  } flaw_e;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [IDX_W-1:0]     index;
    logic                 ok;
    logic                 last;
  } sig_word_t;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           sig_byte_i   = 8'h00;
  logic                 final_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [WORD_BITS-1:0] word_o;
  logic [IDX_W-1:0]     word_index_o;
  logic                 sig_ok_o;
  logic                 run_end_o;

  der_ecdsa_signature_parser_top #(
    .INT_BYTES    (INT_BYTES),
    .MAX_SIG_BYTES(MAX_SIG_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sig_byte_i  (sig_byte_i),
    .final_byte_i(final_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_o      (word_o),
    .word_index_o(word_index_o),
    .sig_ok_o    (sig_ok_o),
    .run_end_o   (run_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Parser state as the testbench sees it.
  phase_e     pm_phase;
  logic [6:0] pm_seen;
  logic [7:0] pm_seq_len;
  logic [5:0] pm_field_len;
  logic [5:0] pm_field_taken;
  logic [7:0] pm_int_bytes [2*INT_BYTES];
  logic       pm_error;

  sig_word_t  expected_words[$];
  logic [7:0] frame_q[$];
  int         mismatches  = 0;
  int         bytes_sent  = 0;
  int         cycle_count = 0;
  int         stall_left  = 0;
  bit         idle_on     = 1'b1;
  bit         stall_on    = 1'b1;
  bit         short_lens  = 1'b0;

  // --------------------------------------------------------------------------
  // Signature parse predictor
  // --------------------------------------------------------------------------
  task automatic clear_parse();
    pm_phase       = PH_SEQ_TAG;
    pm_seen        = '0;
    pm_seq_len     = '0;
    pm_field_len   = '0;
    pm_field_taken = '0;
    pm_error       = 1'b0;
    foreach (pm_int_bytes[i]) pm_int_bytes[i] = 8'h00;
  endtask

  task automatic take_field_len(input logic [7:0] b, input phase_e next_phase);
    if (b == 8'h00 || int'(b) > INT_BYTES + 1) begin
      pm_error = 1'b1;
    end else begin
      pm_field_len   = 6'(b);
      pm_field_taken = '0;
      pm_phase       = next_phase;
    end
  endtask

  // A field one byte longer than the window carries a leading sign byte that
  // must be zero; shorter fields are right-aligned in the window.
  task automatic take_field_byte(input logic [7:0] b, input int base, input phase_e next_phase);
    int taken;
    int pos;
    taken = int'(pm_field_taken);
    if (int'(pm_field_len) == INT_BYTES + 1) begin
      if (taken == 0) begin
        if (b != 8'h00) pm_error = 1'b1;
      end else begin
        pm_int_bytes[base + taken - 1] = b;
      end
    end else begin
      pos = INT_BYTES - int'(pm_field_len) + taken;
      if (pos < INT_BYTES) pm_int_bytes[base + pos] = b;
    end
    pm_field_taken = 6'(taken + 1);
    if (pm_field_taken >= pm_field_len) pm_phase = next_phase;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    sig_word_t w;
    logic      ok;
    if (!pm_error) begin
      case (pm_phase)
        PH_SEQ_TAG: begin
          if (b != SEQ_TAG) pm_error = 1'b1; else pm_phase = PH_SEQ_LEN;
        end
        PH_SEQ_LEN: begin
          pm_seq_len = b;
          pm_phase   = PH_R_TAG;
        end
        PH_R_TAG: begin
          if (b != INT_TAG) pm_error = 1'b1; else pm_phase = PH_R_LEN;
        end
        PH_R_LEN:  take_field_len(b, PH_R_DATA);
        PH_R_DATA: take_field_byte(b, 0, PH_S_TAG);
        PH_S_TAG: begin
          if (b != INT_TAG) pm_error = 1'b1; else pm_phase = PH_S_LEN;
        end
        PH_S_LEN:  take_field_len(b, PH_S_DATA);
        PH_S_DATA: take_field_byte(b, INT_BYTES, PH_DONE);
        default:   pm_error = 1'b1;
      endcase
    end
    // The byte counter saturates; a byte past saturation is an error.
    if (pm_seen == CNT_MAX) pm_error = 1'b1;
    else pm_seen = pm_seen + 7'd1;

    if (fin) begin
      ok = !pm_error && pm_phase == PH_DONE && pm_seen >= MIN_SIG_BYTES &&
           int'(pm_seen) <= MAX_SIG_BYTES && int'(pm_seq_len) + 2 == int'(pm_seen);
      if (ok) begin
        for (int k = 0; k < OUT_WORDS; k++) begin
          w.word = '0;
          for (int j = 0; j < 8; j++)
            w.word = {w.word[WORD_BITS-9:0],
                      pm_int_bytes[(k / 4) * INT_BYTES + (k % 4) * 8 + j]};
          w.index = IDX_W'(k);
          w.ok    = 1'b1;
          w.last  = (k == OUT_WORDS - 1);
          expected_words.push_back(w);
        end
      end else begin
        w = '{word: '0, index: '0, ok: 1'b0, last: 1'b1};
        expected_words.push_back(w);
      end
      clear_parse();
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: checks each word transaction and applies random back-pressure.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_word();
    sig_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("result with nothing expected", word_o, '0);
    end else begin
      want = expected_words.pop_front();
      if (word_o !== want.word) report_mismatch("word", word_o, want.word);
      if (word_index_o !== want.index) report_mismatch("word_index", word_index_o, want.index);
      if (sig_ok_o !== want.ok) report_mismatch("sig_ok", sig_ok_o, want.ok);
      if (run_end_o !== want.last) report_mismatch("run_end", run_end_o, want.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_word();
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Presents one byte, holds it until accepted, then updates the prediction.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sig_byte_i   <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    parse_byte(b, fin);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Holds the input until every predicted word has been delivered.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_integer(input int len);
    frame_q.push_back(INT_TAG);
    frame_q.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if (len == INT_BYTES + 1 && i == 0) frame_q.push_back(8'h00);
      else if (i < 2 && $urandom_range(0, 3) == 0) frame_q.push_back(8'h00);
      else frame_q.push_back(8'($urandom));
    end
  endtask

  task automatic build_frame(input int r_len, input int s_len);
    frame_q = {};
    frame_q.push_back(SEQ_TAG);
    frame_q.push_back(8'(4 + r_len + s_len));
    add_integer(r_len);
    add_integer(s_len);
  endtask

  // Mostly short integers so that many signatures fit in the run.
  function automatic int pick_len();
    int sel;
    if (short_lens) return $urandom_range(1, 2);
    sel = $urandom_range(0, 9);
    if (sel <= 6) return $urandom_range(1, 4);
    else if (sel == 7) return $urandom_range(5, INT_BYTES - 1);
    else if (sel == 8) return INT_BYTES;
    else return INT_BYTES + 1;
  endfunction

  task automatic make_frame(input flaw_e flaw);
    int  r_len;
    int  s_len;
    bit  on_r;
    r_len = pick_len();
    s_len = pick_len();
    on_r  = 1'($urandom_range(0, 1));
    case (flaw)
      FLAW_LEN_ZERO: if (on_r) r_len = 0; else s_len = 0;
      FLAW_SIGN:     if (on_r) r_len = INT_BYTES + 1; else s_len = INT_BYTES + 1;
      default: ;
    endcase
    build_frame(r_len, s_len);
    case (flaw)
      FLAW_SEQ_TAG: frame_q[0] ^= 8'($urandom_range(1, 255));
      FLAW_SEQ_LEN: frame_q[1] ^= 8'($urandom_range(1, 255));
      FLAW_R_TAG:   frame_q[2] ^= 8'($urandom_range(1, 255));
      FLAW_S_TAG:   frame_q[4 + r_len] ^= 8'($urandom_range(1, 255));
      // A length byte past the limit; the data bytes behind it stay short.
      FLAW_LEN_HUGE: begin
        if (on_r) frame_q[3] = 8'($urandom_range(INT_BYTES + 2, 255));
        else frame_q[5 + r_len] = 8'($urandom_range(INT_BYTES + 2, 255));
      end
      FLAW_SIGN: begin
        if (on_r) frame_q[4] = 8'($urandom_range(1, 255));
        else frame_q[6 + r_len] = 8'($urandom_range(1, 255));
      end
      FLAW_SHORT: begin
        repeat ($urandom_range(1, 5)) void'(frame_q.pop_back());
      end
      FLAW_TRAIL: begin
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
        // Sometimes make the sequence length cover the extra bytes as well.
        if ($urandom_range(0, 1)) frame_q[1] = 8'(frame_q.size() - 2);
      end
      FLAW_NOISE: begin
        frame_q = {};
        repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Well-formed signatures at the shortest and the longest total length.
  task automatic test_field_extremes();
    build_frame(1, 1);
    send_frame();
    // Both integers carry a sign byte and fill the whole window with ones.
    build_frame(INT_BYTES + 1, INT_BYTES + 1);
    for (int i = 5; i < 4 + INT_BYTES + 1; i++) frame_q[i] = 8'hFF;
    for (int i = 6 + INT_BYTES + 2; i < 6 + 2 * INT_BYTES + 2; i++) frame_q[i] = 8'hFF;
    send_frame();
    wait_idle();
  endtask

  // One signature for each way of breaking the encoding.
  task automatic test_rejections();
    short_lens = 1'b1;
    frame_q = {SEQ_TAG};
    send_frame();
    for (flaw_e f = FLAW_SEQ_TAG; f <= FLAW_NOISE; f = flaw_e'(f + 1)) begin
      make_frame(f);
      send_frame();
    end
    wait_idle();
    short_lens = 1'b0;
  endtask

  // Mostly well-formed signatures with random contents, the rest broken.
  task automatic test_random_traffic();
    int start_bytes;
    flaw_e flaw;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) != 0) flaw = FLAW_NONE;
      else flaw = flaw_e'($urandom_range(FLAW_SEQ_TAG, FLAW_NOISE));
      make_frame(flaw);
      send_frame();
      // Now and then let the output side empty completely before going on.
      if ($urandom_range(0, 9) == 0) wait_idle();
    end
    wait_idle();
  endtask

  // Back-to-back signatures with no idling on either side.
  task automatic test_quiet_tail();
    idle_on    = 1'b0;
    stall_on   = 1'b0;
    short_lens = 1'b1;
    repeat (3) begin
      make_frame($urandom_range(0, 4) == 0 ? FLAW_SHORT : FLAW_NONE);
      send_frame();
    end
    wait_idle();
  endtask

  initial begin
    clear_parse();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_rejections();
    test_random_traffic();
    test_quiet_tail();

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
